FILE: design/sm3_pkg.sv
// SM3 hash engine: shared types, constants and bit functions.
// Used by every module of the sm3_hash block; no dependencies.
`default_nettype none

package sm3_pkg;

    localparam logic [31:0] SM3_T_LOW    = 32'h79CC4519;
    localparam logic [31:0] SM3_T_HIGH   = 32'h7A879D8A;
    localparam logic [7:0]  SM3_PAD_BYTE = 8'h80;
    localparam logic [31:0] SM3_PAD_WORD = {SM3_PAD_BYTE, 24'h000000};
    localparam logic [3:0]  SM3_LEN_SLOT = 4'd14;
    localparam logic [5:0]  SM3_LAST_ROUND = 6'd63;
    localparam logic [2:0]  SM3_LAST_INDEX = 3'd7;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } digest_beat_t;

    // Sequencer -> core
    typedef struct packed {
        logic        push;
        logic [31:0] word;
        logic        init;
    } core_ctrl_t;

    // Core -> sequencer
    typedef struct packed {
        logic       busy;
        logic [3:0] word_count;
    } core_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_FIN,
        ST_OUT
    } seq_state_t;

    function automatic logic [31:0] sm3_iv(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'h7380166F;
            3'd1:    w = 32'h4914B2B9;
            3'd2:    w = 32'h172442D7;
            3'd3:    w = 32'hDA8A0600;
            3'd4:    w = 32'hA96F30BC;
            3'd5:    w = 32'h163138AA;
            3'd6:    w = 32'hE38DEE4D;
            default: w = 32'hB0FB0E4E;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

`default_nettype wire

FILE: design/sm3_round.sv
// SM3 round logic: one compression round and one message expansion word.
// Depends on sm3_pkg.
`default_nettype none

module sm3_round
    import sm3_pkg::*;
(
    input  wire logic [7:0][31:0]  v_in,
    input  wire logic [15:0][31:0] win,
    input  wire logic [5:0]        round,
    output logic      [7:0][31:0]  v_out,
    output logic      [31:0]       w_new
);

    logic [31:0] a12;
    logic [31:0] tj;
    logic [31:0] ss1;
    logic [31:0] ss2;
    logic [31:0] ff;
    logic [31:0] gg;
    logic [31:0] tt1;
    logic [31:0] tt2;
    logic        early;

    always_comb
    begin
        early = (round[5:4] == 2'b00);
        tj    = early ? SM3_T_LOW : SM3_T_HIGH;
        a12   = rotl32(v_in[0], 5'd12);
        ss1   = rotl32(a12 + v_in[4] + rotl32(tj, round[4:0]), 5'd7);
        ss2   = ss1 ^ a12;
        if (early)
        begin
            ff = v_in[0] ^ v_in[1] ^ v_in[2];
            gg = v_in[4] ^ v_in[5] ^ v_in[6];
        end
        else
        begin
            ff = (v_in[0] & v_in[1]) | (v_in[0] & v_in[2]) | (v_in[1] & v_in[2]);
            gg = (v_in[4] & v_in[5]) | (~v_in[4] & v_in[6]);
        end
        // win[0] is W[j], win[4] is W[j+4]
        tt1 = ff + v_in[3] + ss2 + (win[0] ^ win[4]);
        tt2 = gg + v_in[7] + ss1 + win[0];

        v_out[0] = tt1;
        v_out[1] = v_in[0];
        v_out[2] = rotl32(v_in[1], 5'd9);
        v_out[3] = v_in[2];
        v_out[4] = perm0(tt2);
        v_out[5] = v_in[4];
        v_out[6] = rotl32(v_in[5], 5'd19);
        v_out[7] = v_in[6];

        // W[j+16] from the sliding window
        w_new = perm1(win[0] ^ win[7] ^ rotl32(win[13], 5'd15))
              ^ rotl32(win[3], 5'd7) ^ win[10];
    end

endmodule

`default_nettype wire

FILE: design/sm3_core.sv
// SM3 compression core: 16-word window, working registers, round counter, chain value.
// Depends on sm3_pkg and sm3_round.
`default_nettype none

module sm3_core
    import sm3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire core_ctrl_t       ctrl,
    output core_stat_t            stat,
    output logic      [7:0][31:0] chain
);

    logic [7:0][31:0]  chain_reg;
    logic [7:0][31:0]  v_reg;
    logic [15:0][31:0] win_reg;
    logic [5:0]        round_reg;
    logic [3:0]        wc_reg;
    logic              busy_reg;

    logic [7:0][31:0]  v_rnd;
    logic [31:0]       w_new;
    logic              start;

    sm3_round u_round (
        .v_in  (v_reg),
        .win   (win_reg),
        .round (round_reg),
        .v_out (v_rnd),
        .w_new (w_new)
    );

    // 16th word of a block kicks off the rounds
    assign start = ctrl.push && !busy_reg && (wc_reg == 4'hF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            wc_reg    <= 4'h0;
            round_reg <= 6'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sm3_iv(3'(i));
            end
        end
        else
        begin
            if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == SM3_LAST_ROUND)
                begin
                    busy_reg  <= 1'b0;
                    chain_reg <= chain_reg ^ v_rnd;
                end
            end
            else
            begin
                if (ctrl.push)
                begin
                    wc_reg <= wc_reg + 4'h1;
                end
                if (start)
                begin
                    busy_reg  <= 1'b1;
                    round_reg <= 6'd0;
                end
                if (ctrl.init)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= sm3_iv(3'(i));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            v_reg   <= v_rnd;
            win_reg <= {w_new, win_reg[15:1]};
        end
        else if (ctrl.push)
        begin
            win_reg <= {ctrl.word, win_reg[15:1]};
            if (start)
            begin
                v_reg <= chain_reg;
            end
        end
    end

    assign stat.busy       = busy_reg;
    assign stat.word_count = wc_reg;
    assign chain           = chain_reg;

endmodule

`default_nettype wire

FILE: design/sm3_hash.sv
// SM3 hash engine top level: message intake, padding sequencer, digest output register.
// Depends on sm3_pkg and sm3_core.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  message  | msg_valid / msg_stall      | msg    (data_word, valid_bytes, last)
//  digest   | digest_valid / digest_stall| digest (digest_word, word_index, digest_last)
//
// The 16th word of a block holds msg_stall high for the 64 rounds of the shared round
// unit. After a last word the sequencer pushes padding one word a cycle while the core
// is not busy, runs one or two more compressions, then loads eight digest words through
// the output register. Reset loads the initial chain value; no clearing pass. Digest
// stalls hold off the next digest word, and new message words until the last digest
// word is loaded; message words are taken while that last digest word waits.
`default_nettype none

module sm3_hash
    import sm3_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         msg_valid,
    output logic              msg_stall,
    input  wire msg_beat_t    msg,
    output logic              digest_valid,
    input  wire logic         digest_stall,
    output digest_beat_t      digest
);

    seq_state_t   state_reg;
    seq_state_t   state_next;
    logic [63:0]  len_reg;
    logic [63:0]  len_next;
    logic         pend_reg;
    logic         pend_next;
    logic         hi_done_reg;
    logic         hi_done_next;
    logic [2:0]   idx_reg;
    logic [2:0]   idx_next;
    logic         dv_reg;
    logic         dv_next;
    digest_beat_t dout_reg;
    digest_beat_t dout_next;

    core_ctrl_t       ctrl;
    core_stat_t       stat;
    logic [7:0][31:0] chain;

    logic       accept;
    logic       full_word;
    logic [2:0] vb_eff;
    logic [31:0] tail_word;

    sm3_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .chain (chain)
    );

    assign msg_stall = (state_reg != ST_IDLE) || stat.busy;
    assign accept    = msg_valid && !msg_stall;
    assign full_word = msg.valid_bytes[2];
    assign vb_eff    = full_word ? 3'd4 : msg.valid_bytes;

    // Short tail: keep leading bytes, put the pad byte right after them
    always_comb
    begin
        case (msg.valid_bytes)
            3'd0:    tail_word = SM3_PAD_WORD;
            3'd1:    tail_word = {msg.data_word[31:24], SM3_PAD_BYTE, 16'h0000};
            3'd2:    tail_word = {msg.data_word[31:16], SM3_PAD_BYTE, 8'h00};
            3'd3:    tail_word = {msg.data_word[31:8], SM3_PAD_BYTE};
            default: tail_word = msg.data_word;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= 64'd0;
            pend_reg    <= 1'b0;
            hi_done_reg <= 1'b0;
            idx_reg     <= 3'd0;
            dv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            pend_reg    <= pend_next;
            hi_done_reg <= hi_done_next;
            idx_reg     <= idx_next;
            dv_reg      <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        pend_next    = pend_reg;
        hi_done_next = hi_done_reg;
        idx_next     = idx_reg;
        dv_next      = dv_reg && digest_stall;
        dout_next    = dout_reg;
        ctrl.push    = 1'b0;
        ctrl.word    = 32'h0;
        ctrl.init    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.push = 1'b1;
                    if (!msg.last)
                    begin
                        ctrl.word = msg.data_word;
                        len_next  = len_reg + 64'd32;
                    end
                    else
                    begin
                        ctrl.word    = tail_word;
                        len_next     = len_reg + 64'({vb_eff, 3'b000});
                        pend_next    = full_word;
                        hi_done_next = 1'b0;
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (!stat.busy)
                begin
                    ctrl.push = 1'b1;
                    if (pend_reg)
                    begin
                        ctrl.word = SM3_PAD_WORD;
                        pend_next = 1'b0;
                    end
                    else if (hi_done_reg)
                    begin
                        ctrl.word  = len_reg[31:0];
                        state_next = ST_FIN;
                    end
                    else if (stat.word_count == SM3_LEN_SLOT)
                    begin
                        ctrl.word    = len_reg[63:32];
                        hi_done_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.word = 32'h0;
                    end
                end
            end
            ST_FIN:
            begin
                if (!stat.busy)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!dv_reg || !digest_stall)
                begin
                    dv_next               = 1'b1;
                    dout_next.digest_word = chain[idx_reg];
                    dout_next.word_index  = idx_reg;
                    dout_next.digest_last = (idx_reg == SM3_LAST_INDEX);
                    idx_next              = idx_reg + 3'd1;
                    if (idx_reg == SM3_LAST_INDEX)
                    begin
                        // chain already sampled above; restart for the next message
                        ctrl.init  = 1'b1;
                        len_next   = 64'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign digest_valid = dv_reg;
    assign digest       = dout_reg;

endmodule

`default_nettype wire

FILE: design/sm3_hash_chk.sv
// Port-level checker for sm3_hash, attached by the bind at the end of this file.
// Depends on sm3_pkg and the sm3_hash top level.
`default_nettype none

module sm3_hash_chk
    import sm3_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         msg_valid,
    input wire logic         msg_stall,
    input wire msg_beat_t    msg,
    input wire logic         digest_valid,
    input wire logic         digest_stall,
    input wire digest_beat_t digest
);

    // stalled digest beat holds
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest))
        else $error("digest beat changed while stalled");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.digest_last == (digest.word_index == SM3_LAST_INDEX)))
        else $error("digest_last does not match word_index");

    a_tail_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_stall && msg.last |=> msg_stall)
        else $error("message taken right after a last word");

    a_busy_in_digest: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && (digest.word_index != SM3_LAST_INDEX) |-> msg_stall)
        else $error("message accepted in the middle of a digest");

    a_digest_starts: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (digest.word_index == 3'd0))
        else $error("digest did not start at word 0");

endmodule

bind sm3_hash sm3_hash_chk u_chk (.*);

`default_nettype wire
